/* rtl/iqrfd_pkg.sv */
package iqrfd_pkg;

    // filter geometry
    localparam int TAP_COUNT = 8;
    localparam int LINE_LEN  = TAP_COUNT - 1;
    localparam int TAP_IDX_W = $clog2(TAP_COUNT);
    localparam int STEP_W    = $clog2(TAP_COUNT + 1);

    // number formats
    localparam int FRAC_BITS  = 14;
    localparam int BYTE_W     = 8;
    localparam int CEN_W      = BYTE_W + 2;
    localparam int COEF_W     = 16;
    localparam int SAMPLE_W   = 12;
    localparam int OUT_W      = 16;
    localparam int PROT_W     = CEN_W + COEF_W;
    localparam int ROT_SUM_W  = PROT_W + 1;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int ACC_W      = PROD_W + $clog2(TAP_COUNT) + 1;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int TAPS_PER_REG = CFG_DATA_W / COEF_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROT_REAL   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROT_IMAG   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_Q   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAPS_FIRST = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAPS_LAST  = 3'd4;

    localparam logic signed [COEF_W-1:0] ROT_REAL_RESET   = 16'sd16384;
    localparam logic signed [COEF_W-1:0] ROT_IMAG_RESET   = 16'sd0;
    localparam logic [CFG_DATA_W-1:0]    TAPS_FIRST_RESET = 64'h4000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0]    TAPS_LAST_RESET  = 64'h0;

    // byte centring offset
    localparam logic signed [CEN_W-1:0] CEN_OFFSET = CEN_W'(255);

    // rounding and saturation limits
    localparam logic signed [ROT_SUM_W-1:0] ROT_HALF = ROT_SUM_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [ROT_SUM_W-1:0] ROT_MAX  = ROT_SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ROT_SUM_W-1:0] ROT_MIN  = -ROT_SUM_W'(1 << (SAMPLE_W - 1));
    localparam logic signed [ACC_W-1:0]     ACC_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]     OUT_MAX  = ACC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0]     OUT_MIN  = -ACC_W'(1 << (OUT_W - 1));

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } cplx_t;

    typedef struct packed {
        cplx_t x;
        logic  chunk_end;
    } qentry_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] re;
        logic signed [COEF_W-1:0] im;
        logic                     invert;
    } rot_cfg_t;

    typedef logic [TAP_COUNT-1:0][COEF_W-1:0] tap_vec_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_FIN
    } back_state_t;

    // round half up from Q2.14, clamp to the rotated sample range
    function automatic logic signed [SAMPLE_W-1:0] round_sat_rot(
        input logic signed [ROT_SUM_W-1:0] v
    );
        logic signed [ROT_SUM_W-1:0] r;
        r = (v + ROT_HALF) >>> FRAC_BITS;
        if (r > ROT_MAX) begin
            return ROT_MAX[SAMPLE_W-1:0];
        end else if (r < ROT_MIN) begin
            return ROT_MIN[SAMPLE_W-1:0];
        end
        return r[SAMPLE_W-1:0];
    endfunction

    // round half up from Q2.14, clamp to the output range
    function automatic logic signed [OUT_W-1:0] round_sat_out(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] r;
        r = (v + ACC_HALF) >>> FRAC_BITS;
        if (r > OUT_MAX) begin
            return OUT_MAX[OUT_W-1:0];
        end else if (r < OUT_MIN) begin
            return OUT_MIN[OUT_W-1:0];
        end
        return r[OUT_W-1:0];
    endfunction

endpackage

/* rtl/iqrfd_sample_if.sv */
interface iqrfd_sample_if;
    import iqrfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] i_byte;
    logic [BYTE_W-1:0] q_byte;
    logic              chunk_end;

    modport source (output valid, output i_byte, output q_byte, output chunk_end,
                    input ready);
    modport sink (input valid, input i_byte, input q_byte, input chunk_end,
                  output ready);
endinterface

/* rtl/iqrfd_result_if.sv */
interface iqrfd_result_if;
    import iqrfd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_real;
    logic signed [OUT_W-1:0] out_imag;
    logic                    out_chunk_end;

    modport source (output valid, output out_real, output out_imag, output out_chunk_end,
                    input ready);
    modport sink (input valid, input out_real, input out_imag, input out_chunk_end,
                  output ready);
endinterface

/* rtl/iqrfd_cfg_if.sv */
interface iqrfd_cfg_if;
    import iqrfd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/iqrfd_front.sv */
module iqrfd_front
    import iqrfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    iqrfd_sample_if.sink      samples,
    input  rot_cfg_t          rot_cfg,
    input  logic [QCNT_W-1:0] q_count,
    output logic              q_push,
    output qentry_t           q_data,
    output logic              busy
);

    logic                     valid_a_reg;
    logic                     chunk_a_reg;
    logic signed [PROT_W-1:0] p_ir_reg;
    logic signed [PROT_W-1:0] p_qi_reg;
    logic signed [PROT_W-1:0] p_ii_reg;
    logic signed [PROT_W-1:0] p_qr_reg;

    logic                     accept;
    logic signed [CEN_W-1:0]  ci;
    logic signed [CEN_W-1:0]  cq_raw;
    logic signed [CEN_W-1:0]  cq;
    logic signed [ROT_SUM_W-1:0] sum_re;
    logic signed [ROT_SUM_W-1:0] sum_im;

    // take a beat only when the queue has room for everything in flight
    assign samples.ready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(valid_a_reg))
                           < (QCNT_W + 1)'(QDEPTH);
    assign accept = samples.valid && samples.ready;

    // centre the bytes as 2*b - 255, optional spectral inversion of q
    assign ci     = $signed({1'b0, samples.i_byte, 1'b0}) - CEN_OFFSET;
    assign cq_raw = $signed({1'b0, samples.q_byte, 1'b0}) - CEN_OFFSET;
    assign cq     = rot_cfg.invert ? -cq_raw : cq_raw;

    // stage a: the four partial products of the complex rotation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_ir_reg    <= ci * rot_cfg.re;
            p_qi_reg    <= cq * rot_cfg.im;
            p_ii_reg    <= ci * rot_cfg.im;
            p_qr_reg    <= cq * rot_cfg.re;
            chunk_a_reg <= samples.chunk_end;
        end
    end

    // stage b: combine, round and clamp, then straight into the queue
    assign sum_re = ROT_SUM_W'(p_ir_reg) - ROT_SUM_W'(p_qi_reg);
    assign sum_im = ROT_SUM_W'(p_ii_reg) + ROT_SUM_W'(p_qr_reg);

    assign q_push         = valid_a_reg;
    assign q_data.x.re    = round_sat_rot(sum_re);
    assign q_data.x.im    = round_sat_rot(sum_im);
    assign q_data.chunk_end = chunk_a_reg;
    assign busy           = valid_a_reg;

endmodule

/* rtl/iqrfd_queue.sv */
module iqrfd_queue
    import iqrfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qentry_t           push_data,
    input  logic              pop,
    output qentry_t           head,
    output logic [QCNT_W-1:0] count
);

    qentry_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/iqrfd_back.sv */
module iqrfd_back
    import iqrfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  tap_vec_t      taps,
    input  logic          q_valid,
    input  qentry_t       q_head,
    output logic          q_pop,
    iqrfd_result_if.source results
);

    back_state_t             state_reg, state_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    cplx_t                   cur_reg, cur_next;
    logic                    chunk_reg, chunk_next;
    cplx_t                   line_reg [LINE_LEN];
    cplx_t                   line_next [LINE_LEN];
    logic signed [PROD_W-1:0] prod_re_reg, prod_re_next;
    logic signed [PROD_W-1:0] prod_im_reg, prod_im_next;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_re_next;
    logic signed [ACC_W-1:0]  acc_im_reg, acc_im_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] out_re_reg, out_re_next;
    logic signed [OUT_W-1:0] out_im_reg, out_im_next;
    logic                    out_chunk_reg, out_chunk_next;

    cplx_t                   win [TAP_COUNT];
    cplx_t                   win_sel;
    logic signed [COEF_W-1:0] tap_sel;
    logic                    out_free;

    // window: current sample then the delay line, newest first
    always_comb
    begin
        win[0] = cur_reg;
        for (int j = 1; j < TAP_COUNT; j++)
        begin
            win[j] = line_reg[j-1];
        end
    end

    assign win_sel  = win[step_reg[TAP_IDX_W-1:0]];
    assign tap_sel  = $signed(taps[step_reg[TAP_IDX_W-1:0]]);
    assign out_free = !out_valid_reg || results.ready;

    // sequencer: one tap per cycle through a shared multiplier pair
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cur_next       = cur_reg;
        chunk_next     = chunk_reg;
        line_next      = line_reg;
        prod_re_next   = prod_re_reg;
        prod_im_next   = prod_im_reg;
        acc_re_next    = acc_re_reg;
        acc_im_next    = acc_im_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_re_next    = out_re_reg;
        out_im_next    = out_im_reg;
        out_chunk_next = out_chunk_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    cur_next    = q_head.x;
                    chunk_next  = q_head.chunk_end;
                    step_next   = '0;
                    acc_re_next = '0;
                    acc_im_next = '0;
                    state_next  = BK_MAC;
                end
            end
            BK_MAC:
            begin
                if (step_reg < STEP_W'(TAP_COUNT))
                begin
                    prod_re_next = tap_sel * win_sel.re;
                    prod_im_next = tap_sel * win_sel.im;
                end
                if (step_reg != '0)
                begin
                    acc_re_next = acc_re_reg + ACC_W'(prod_re_reg);
                    acc_im_next = acc_im_reg + ACC_W'(prod_im_reg);
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(TAP_COUNT))
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_re_next    = round_sat_out(acc_re_reg);
                    out_im_next    = round_sat_out(acc_im_reg);
                    out_chunk_next = chunk_reg;
                    line_next[0]   = cur_reg;
                    for (int j = 1; j < LINE_LEN; j++)
                    begin
                        line_next[j] = line_reg[j-1];
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control and delay line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < LINE_LEN; j++)
            begin
                line_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            line_reg      <= line_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        chunk_reg     <= chunk_next;
        prod_re_reg   <= prod_re_next;
        prod_im_reg   <= prod_im_next;
        acc_re_reg    <= acc_re_next;
        acc_im_reg    <= acc_im_next;
        out_re_reg    <= out_re_next;
        out_im_reg    <= out_im_next;
        out_chunk_reg <= out_chunk_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.out_real      = out_re_reg;
    assign results.out_imag      = out_im_reg;
    assign results.out_chunk_end = out_chunk_reg;

endmodule

/* rtl/iq_rotate_fractional_delay_fir.sv */
// I/Q phase rotation followed by an 8-tap fractional-delay FIR.
// samples: one beat carries a raw unsigned I/Q byte pair and a chunk_end mark.
// Each byte is centred as 2*b-255, q optionally negated, the pair rotated by
// the complex Q2.14 phasor and clamped to 12 bits, then filtered with the real
// Q2.14 taps over the current sample and the seven before it.
// results: one beat per sample beat, in order, 16-bit saturated real and
// imaginary parts with chunk_end copied through.
// cfg: register writes by index (0 phasor real, 1 phasor imaginary, 2 q
// inversion, 3 taps 0..3, 4 taps 4..7); always ready, unknown indexes ignored;
// write only while no sample is in flight.
// An accepted sample beat passes the rotation register, the queue, the back end's
// idle, MAC and finish states and then the output register.
// The back end sets the sample rate: it runs every tap through one shared
// multiplier pair and then rounds before it takes the next sample.
// A four-entry queue after the rotation stage lets the input keep flowing
// while the filter works or the receiver stalls; a stalled result stays in
// the output register and the filter holds once that register is full.
// Reset clears the delay line to zero, empties the queue and restores the
// register defaults (unit phasor, tap 3 = 1.0, all other taps zero).
module iq_rotate_fractional_delay_fir
    import iqrfd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    iqrfd_sample_if.sink   samples,
    iqrfd_result_if.source results,
    iqrfd_cfg_if.sink      cfg
);

    logic signed [COEF_W-1:0] rot_real_reg;
    logic signed [COEF_W-1:0] rot_imag_reg;
    logic                     invert_reg;
    logic [CFG_DATA_W-1:0]    taps_first_reg;
    logic [CFG_DATA_W-1:0]    taps_last_reg;

    rot_cfg_t          rot_cfg;
    tap_vec_t          taps;
    logic              q_push;
    logic              q_pop;
    qentry_t           q_in;
    qentry_t           q_head;
    logic [QCNT_W-1:0] q_count;
    logic              front_busy;

    // configuration register file
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_real_reg   <= ROT_REAL_RESET;
            rot_imag_reg   <= ROT_IMAG_RESET;
            invert_reg     <= 1'b0;
            taps_first_reg <= TAPS_FIRST_RESET;
            taps_last_reg  <= TAPS_LAST_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ROT_REAL:   rot_real_reg   <= $signed(cfg.data[COEF_W-1:0]);
                CFG_ROT_IMAG:   rot_imag_reg   <= $signed(cfg.data[COEF_W-1:0]);
                CFG_INVERT_Q:   invert_reg     <= cfg.data[0];
                CFG_TAPS_FIRST: taps_first_reg <= cfg.data;
                CFG_TAPS_LAST:  taps_last_reg  <= cfg.data;
                default:        ;
            endcase
        end
    end

    assign rot_cfg.re     = rot_real_reg;
    assign rot_cfg.im     = rot_imag_reg;
    assign rot_cfg.invert = invert_reg;

    // unpack the tap words, taps past the two registers read as zero
    always_comb
    begin
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            if (k < TAPS_PER_REG)
            begin
                taps[k] = taps_first_reg[COEF_W*(k % TAPS_PER_REG) +: COEF_W];
            end
            else if (k < 2 * TAPS_PER_REG)
            begin
                taps[k] = taps_last_reg[COEF_W*(k % TAPS_PER_REG) +: COEF_W];
            end
            else
            begin
                taps[k] = '0;
            end
        end
    end

    // rotation front end
    iqrfd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .rot_cfg (rot_cfg),
        .q_count (q_count),
        .q_push  (q_push),
        .q_data  (q_in),
        .busy    (front_busy)
    );

    // decoupling queue
    iqrfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .count     (q_count)
    );

    // filter back end
    iqrfd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .taps    (taps),
        .q_valid (q_count != '0),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .results (results)
    );

`ifndef NO_ASSERTIONS
    // the front end credit check keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_pop |-> q_count != QCNT_W'(QDEPTH))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_count != '0)
        else $error("queue pop while empty");

    // every accepted sample beat reaches the rotation stage
    a_front_capture: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> front_busy && q_push)
        else $error("accepted beat lost before the queue");
`endif

endmodule
